### hw/rtl/vau_pkg.sv
// Shared types and constants for the versatile interface adapter.
// Holds the request kind codes, the register map and the flag bit positions.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package vau_pkg;

   // Request kinds carried in req_tuser.
   typedef enum logic [2:0] {
      OP_READ      = 3'd0,
      OP_WRITE     = 3'd1,
      OP_TICK      = 3'd2,
      OP_SET_PIN   = 3'd3,
      OP_SET_LINE  = 3'd4,
      OP_SHIFT_IN  = 3'd5
   } op_type;

   // Bus register map.
   typedef enum logic [3:0] {
      REG_ORB    = 4'd0,
      REG_ORA    = 4'd1,
      REG_DDRB   = 4'd2,
      REG_DDRA   = 4'd3,
      REG_T1C_L  = 4'd4,
      REG_T1C_H  = 4'd5,
      REG_T1L_L  = 4'd6,
      REG_T1L_H  = 4'd7,
      REG_T2C_L  = 4'd8,
      REG_T2C_H  = 4'd9,
      REG_SR     = 4'd10,
      REG_ACR    = 4'd11,
      REG_PCR    = 4'd12,
      REG_IFR    = 4'd13,
      REG_IER    = 4'd14,
      REG_ORA_HS = 4'd15
   } reg_sel_type;

   // Interrupt flag bit positions.
   localparam int unsigned FLAG_CA2 = 0;
   localparam int unsigned FLAG_CA1 = 1;
   localparam int unsigned FLAG_SR  = 2;
   localparam int unsigned FLAG_CB2 = 3;
   localparam int unsigned FLAG_CB1 = 4;
   localparam int unsigned FLAG_T2  = 5;
   localparam int unsigned FLAG_T1  = 6;

   // Timer 1 modes from ACR bits 7:6.
   localparam logic [1:0] T1_ONESHOT_PB7 = 2'd2;

   // Shift-in is taken in this ACR shift mode (bits 3:2) with bit 4 clear.
   localparam logic [1:0] SR_MODE_EXT_IN = 2'd3;

   // Ticks from an SR write in output mode to the completed shift-out.
   localparam logic [3:0] SHIFT_TICKS = 4'd8;

   // Timer reload value after a stop or wrap.
   localparam logic [15:0] TIMER_ALL_ONES = 16'hFFFF;

   // Input pin levels after reset.
   localparam logic [7:0] PIN_A_RESET = 8'hF7;
   localparam logic [7:0] PIN_B_RESET = 8'hFF;

   // Stream widths.
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 40;

endpackage : vau_pkg

`default_nettype wire

### hw/rtl/versatile_interface_adapter_unit.sv
// Top level of the versatile interface adapter: bus registers, ports, timers,
// shift register and interrupt logic behind a request and a result stream.
// Depends on vau_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Usage
// Each request on the req_ stream is one of: register read, register write,
// adapter clock tick, port pin change, control line change, or shift-in byte.
// The kind travels in req_tuser, the remaining fields in req_tdata. Every
// request produces exactly one result on the rsp_ stream carrying the read
// byte, the interrupt level, both port drive values and a finished
// shift-out byte (rsp_tuser marks that the byte is valid).
// A request is captured in an input register; once the result register is free
// it updates the adapter state and loads the result register, so each result
// reflects the state after its request.
// The update logic is a single short pass, so one request is taken and one
// result delivered per cycle when the receiver keeps rsp_tready high.
// When the receiver stalls, the result stays in its register, the pending
// request waits in the input register and req_tready drops only once both
// are full; no state changes while stalled.
// Synchronous reset clears the streams and returns the adapter state registers to their
// power-up values (port A pins read 0xF7, port B pins 0xFF).

module versatile_interface_adapter_unit (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 req_tvalid,
   output logic                                req_tready,
   // tdata: reg_select[3:0], write_data[11:4], port_select[12],
   //        pin_index[15:13], line_select[16], zero fill above
   input  wire  [vau_pkg::REQ_DATA_W-1:0]      req_tdata,
   // tuser: op[2:0]
   input  wire  [2:0]                          req_tuser,
   output logic                                rsp_tvalid,
   input  wire                                 rsp_tready,
   // tdata: read_data[7:0], irq[8], port_a_drive[16:9], port_b_drive[24:17],
   //        shift_out_byte[32:25], zero fill above
   output logic [vau_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   // tuser: shift_out_valid[0]
   output logic                                rsp_tuser
);

   // Stream control
   logic        s1_valid_ff, s1_valid_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        adv, fire, req_fire;

   // Input register payload
   logic [2:0]  s1_op_ff;
   logic [3:0]  s1_rs_ff;
   logic [7:0]  s1_wd_ff;
   logic        s1_ps_ff;
   logic [2:0]  s1_pin_ff;
   logic        s1_ls_ff;

   // Result register payload
   logic [7:0]  rsp_rd_ff, rsp_pa_ff, rsp_pb_ff, rsp_shb_ff;
   logic        rsp_irq_ff, rsp_shv_ff;

   // Adapter state
   logic [7:0]  sr_ff, sr_in;
   logic [7:0]  acr_ff, acr_in;
   logic [7:0]  pcr_ff, pcr_in;
   logic [6:0]  ifr_ff, ifr_in;
   logic [6:0]  ier_ff, ier_in;
   logic        sh_pend_ff, sh_pend_in;
   logic [7:0]  sh_data_ff, sh_data_in;
   logic [3:0]  sh_cnt_ff, sh_cnt_in;
   logic [15:0] t1_cnt_ff, t1_cnt_in;
   logic [15:0] t1_latch_ff, t1_latch_in;
   logic        t1_run_ff, t1_run_in;
   logic [15:0] t2_cnt_ff, t2_cnt_in;
   logic [15:0] t2_latch_ff, t2_latch_in;
   logic        t2_run_ff, t2_run_in;
   logic        t2_exp_ff, t2_exp_in;
   logic [7:0]  ora_ff, ora_in;
   logic [7:0]  orb_ff, orb_in;
   logic [7:0]  ddra_ff, ddra_in;
   logic [7:0]  ddrb_ff, ddrb_in;
   logic [7:0]  pina_ff, pina_in;
   logic [7:0]  pinb_ff, pinb_in;
   logic [3:0]  ctrl_ff, ctrl_in;

   // Per-request results and helpers
   logic [7:0]  rd_val;
   logic        shv_val;
   logic [7:0]  shb_val;
   logic [7:0]  port_a_val, port_b_val;
   logic        irq_now;
   logic [1:0]  line_idx;
   logic        line_old, line_pos, line_active, line_edge;
   logic [2:0]  line_mode;

   // Handshake: the input register moves on whenever the result register frees.
   assign adv        = !rsp_valid_ff || rsp_tready;
   assign fire       = s1_valid_ff && adv;
   assign req_tready = !s1_valid_ff || adv;
   assign req_fire   = req_tvalid && req_tready;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_fire) begin
         s1_valid_in = 1'b1;
      end else if (fire) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Port read values mix output register and pin levels by direction.
   assign port_a_val = (ora_ff & ddra_ff) | (pina_ff & ~ddra_ff);
   assign port_b_val = (orb_ff & ddrb_ff) | (pinb_ff & ~ddrb_ff);
   assign irq_now    = |(ifr_ff & ier_ff);

   // Control line edge detection for the selected line.
   assign line_idx    = {s1_ps_ff, s1_ls_ff};
   assign line_old    = ctrl_ff[line_idx];
   assign line_mode   = s1_ps_ff ? pcr_ff[7:5] : pcr_ff[3:1];
   assign line_active = !s1_ls_ff || !line_mode[2];
   assign line_pos    = s1_ls_ff ? line_mode[1] : (s1_ps_ff ? pcr_ff[4] : pcr_ff[0]);
   assign line_edge   = line_pos ? (!line_old && s1_wd_ff[0]) : (line_old && !s1_wd_ff[0]);

   // Next state for one request.
   always_comb begin
      sr_in       = sr_ff;
      acr_in      = acr_ff;
      pcr_in      = pcr_ff;
      ifr_in      = ifr_ff;
      ier_in      = ier_ff;
      sh_pend_in  = sh_pend_ff;
      sh_data_in  = sh_data_ff;
      sh_cnt_in   = sh_cnt_ff;
      t1_cnt_in   = t1_cnt_ff;
      t1_latch_in = t1_latch_ff;
      t1_run_in   = t1_run_ff;
      t2_cnt_in   = t2_cnt_ff;
      t2_latch_in = t2_latch_ff;
      t2_run_in   = t2_run_ff;
      t2_exp_in   = t2_exp_ff;
      ora_in      = ora_ff;
      orb_in      = orb_ff;
      ddra_in     = ddra_ff;
      ddrb_in     = ddrb_ff;
      pina_in     = pina_ff;
      pinb_in     = pinb_ff;
      ctrl_in     = ctrl_ff;
      rd_val      = 8'd0;
      shv_val     = 1'b0;
      shb_val     = 8'd0;

      if (fire) begin
         case (vau_pkg::op_type'(s1_op_ff))
            vau_pkg::OP_READ: begin
               case (vau_pkg::reg_sel_type'(s1_rs_ff))
                  vau_pkg::REG_ORB: begin
                     ifr_in[vau_pkg::FLAG_CB1] = 1'b0;
                     ifr_in[vau_pkg::FLAG_CB2] = 1'b0;
                     rd_val = port_b_val;
                  end
                  vau_pkg::REG_ORA:   rd_val = port_a_val;
                  vau_pkg::REG_DDRB:  rd_val = ddrb_ff;
                  vau_pkg::REG_DDRA:  rd_val = ddra_ff;
                  vau_pkg::REG_T1C_L: begin
                     ifr_in[vau_pkg::FLAG_T1] = 1'b0;
                     rd_val = t1_cnt_ff[7:0];
                  end
                  vau_pkg::REG_T1C_H: rd_val = t1_cnt_ff[15:8];
                  vau_pkg::REG_T1L_L: rd_val = t1_latch_ff[7:0];
                  vau_pkg::REG_T1L_H: rd_val = t1_latch_ff[15:8];
                  vau_pkg::REG_T2C_L: begin
                     ifr_in[vau_pkg::FLAG_T2] = 1'b0;
                     rd_val = t2_cnt_ff[7:0];
                  end
                  vau_pkg::REG_T2C_H: rd_val = t2_cnt_ff[15:8];
                  vau_pkg::REG_SR: begin
                     ifr_in[vau_pkg::FLAG_SR] = 1'b0;
                     rd_val = sr_ff;
                  end
                  vau_pkg::REG_ACR:   rd_val = acr_ff;
                  vau_pkg::REG_PCR:   rd_val = pcr_ff;
                  vau_pkg::REG_IFR:   rd_val = {irq_now, ifr_ff};
                  vau_pkg::REG_IER:   rd_val = {1'b1, ier_ff};
                  vau_pkg::REG_ORA_HS: begin
                     ifr_in[vau_pkg::FLAG_CA1] = 1'b0;
                     ifr_in[vau_pkg::FLAG_CA2] = 1'b0;
                     rd_val = port_a_val;
                  end
                  default: rd_val = 8'd0;
               endcase
            end

            vau_pkg::OP_WRITE: begin
               case (vau_pkg::reg_sel_type'(s1_rs_ff))
                  vau_pkg::REG_ORB: begin
                     orb_in = s1_wd_ff;
                     ifr_in[vau_pkg::FLAG_CB1] = 1'b0;
                     ifr_in[vau_pkg::FLAG_CB2] = 1'b0;
                  end
                  vau_pkg::REG_DDRB:  ddrb_in = s1_wd_ff;
                  vau_pkg::REG_DDRA:  ddra_in = s1_wd_ff;
                  vau_pkg::REG_T1C_L, vau_pkg::REG_T1L_L: begin
                     t1_latch_in = {t1_latch_ff[15:8], s1_wd_ff};
                  end
                  vau_pkg::REG_T1C_H: begin
                     // Load and start timer 1; the one-shot PB7 mode drives PB7 low.
                     ifr_in[vau_pkg::FLAG_T1] = 1'b0;
                     t1_latch_in = {s1_wd_ff, t1_latch_ff[7:0]};
                     t1_cnt_in   = {s1_wd_ff, t1_latch_ff[7:0]};
                     t1_run_in   = 1'b1;
                     if (acr_ff[7:6] == vau_pkg::T1_ONESHOT_PB7 && ddrb_ff[7]) begin
                        orb_in[7] = 1'b0;
                     end
                  end
                  vau_pkg::REG_T1L_H: t1_latch_in = {s1_wd_ff, t1_latch_ff[7:0]};
                  vau_pkg::REG_T2C_L: t2_latch_in = {t2_latch_ff[15:8], s1_wd_ff};
                  vau_pkg::REG_T2C_H: begin
                     // Pulse-count mode only loads; interval mode also starts.
                     ifr_in[vau_pkg::FLAG_T2] = 1'b0;
                     t2_latch_in = {s1_wd_ff, t2_latch_ff[7:0]};
                     t2_cnt_in   = {s1_wd_ff, t2_latch_ff[7:0]};
                     t2_exp_in   = 1'b0;
                     t2_run_in   = !acr_ff[5];
                  end
                  vau_pkg::REG_SR: begin
                     sr_in = s1_wd_ff;
                     ifr_in[vau_pkg::FLAG_SR] = 1'b0;
                     if (acr_ff[4]) begin
                        sh_data_in = s1_wd_ff;
                        sh_pend_in = 1'b1;
                        sh_cnt_in  = vau_pkg::SHIFT_TICKS;
                     end
                  end
                  vau_pkg::REG_ACR: begin
                     // A change of shift mode drops a shift-out in progress.
                     if ((acr_ff[4:2] != s1_wd_ff[4:2]) && sh_pend_ff) begin
                        sh_pend_in = 1'b0;
                        sh_cnt_in  = 4'd0;
                     end
                     acr_in = s1_wd_ff;
                  end
                  vau_pkg::REG_PCR:   pcr_in = s1_wd_ff;
                  vau_pkg::REG_IFR:   ifr_in = ifr_ff & ~s1_wd_ff[6:0];
                  vau_pkg::REG_IER: begin
                     if (s1_wd_ff[7]) begin
                        ier_in = ier_ff | s1_wd_ff[6:0];
                     end else begin
                        ier_in = ier_ff & ~s1_wd_ff[6:0];
                     end
                  end
                  default: begin
                     // Both ORA addresses write the port A output register.
                     ora_in = s1_wd_ff;
                     ifr_in[vau_pkg::FLAG_CA1] = 1'b0;
                     ifr_in[vau_pkg::FLAG_CA2] = 1'b0;
                  end
               endcase
            end

            vau_pkg::OP_TICK: begin
               // Timer 1: time out at zero, then reload or stop.
               if (t1_run_ff) begin
                  if (t1_cnt_ff == 16'd0) begin
                     if (acr_ff[6]) begin
                        t1_cnt_in = t1_latch_ff;
                        if (acr_ff[7] && ddrb_ff[7]) begin
                           orb_in[7] = ~orb_ff[7];
                        end
                     end else begin
                        t1_run_in = 1'b0;
                        t1_cnt_in = vau_pkg::TIMER_ALL_ONES;
                        if (acr_ff[7] && ddrb_ff[7]) begin
                           orb_in[7] = 1'b1;
                        end
                     end
                     ifr_in[vau_pkg::FLAG_T1] = 1'b1;
                  end else begin
                     t1_cnt_in = t1_cnt_ff - 16'd1;
                  end
               end
               // Timer 2: wraps and keeps counting, flags only the first timeout.
               if (t2_run_ff) begin
                  if (t2_cnt_ff == 16'd0) begin
                     t2_cnt_in = vau_pkg::TIMER_ALL_ONES;
                     if (!t2_exp_ff) begin
                        t2_exp_in = 1'b1;
                        ifr_in[vau_pkg::FLAG_T2] = 1'b1;
                     end
                  end else begin
                     t2_cnt_in = t2_cnt_ff - 16'd1;
                  end
               end
               // Shift-out countdown.
               if (sh_pend_ff) begin
                  if (sh_cnt_ff <= 4'd1) begin
                     sh_cnt_in  = 4'd0;
                     sh_pend_in = 1'b0;
                     shv_val    = 1'b1;
                     shb_val    = sh_data_ff;
                     ifr_in[vau_pkg::FLAG_SR] = 1'b1;
                  end else begin
                     sh_cnt_in = sh_cnt_ff - 4'd1;
                  end
               end
            end

            vau_pkg::OP_SET_PIN: begin
               if (s1_ps_ff) begin
                  pinb_in[s1_pin_ff] = s1_wd_ff[0];
               end else begin
                  pina_in[s1_pin_ff] = s1_wd_ff[0];
               end
            end

            vau_pkg::OP_SET_LINE: begin
               // Level is always stored; CA2/CB2 in an output mode raise no flag.
               ctrl_in[line_idx] = s1_wd_ff[0];
               if (line_active && line_edge) begin
                  case (line_idx)
                     2'd0:    ifr_in[vau_pkg::FLAG_CA1] = 1'b1;
                     2'd1:    ifr_in[vau_pkg::FLAG_CA2] = 1'b1;
                     2'd2:    ifr_in[vau_pkg::FLAG_CB1] = 1'b1;
                     default: ifr_in[vau_pkg::FLAG_CB2] = 1'b1;
                  endcase
               end
            end

            vau_pkg::OP_SHIFT_IN: begin
               if (!acr_ff[4] && acr_ff[3:2] == vau_pkg::SR_MODE_EXT_IN) begin
                  sr_in = s1_wd_ff;
                  ifr_in[vau_pkg::FLAG_SR] = 1'b1;
               end
            end

            default: begin
               sr_in = sr_ff;
            end
         endcase
      end
   end

   // Stream control registers and adapter state.
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         sr_ff        <= 8'd0;
         acr_ff       <= 8'd0;
         pcr_ff       <= 8'd0;
         ifr_ff       <= 7'd0;
         ier_ff       <= 7'd0;
         sh_pend_ff   <= 1'b0;
         sh_data_ff   <= 8'd0;
         sh_cnt_ff    <= 4'd0;
         t1_cnt_ff    <= 16'd0;
         t1_latch_ff  <= 16'd0;
         t1_run_ff    <= 1'b0;
         t2_cnt_ff    <= 16'd0;
         t2_latch_ff  <= 16'd0;
         t2_run_ff    <= 1'b0;
         t2_exp_ff    <= 1'b0;
         ora_ff       <= 8'd0;
         orb_ff       <= 8'd0;
         ddra_ff      <= 8'd0;
         ddrb_ff      <= 8'd0;
         pina_ff      <= vau_pkg::PIN_A_RESET;
         pinb_ff      <= vau_pkg::PIN_B_RESET;
         ctrl_ff      <= 4'd0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         sr_ff        <= sr_in;
         acr_ff       <= acr_in;
         pcr_ff       <= pcr_in;
         ifr_ff       <= ifr_in;
         ier_ff       <= ier_in;
         sh_pend_ff   <= sh_pend_in;
         sh_data_ff   <= sh_data_in;
         sh_cnt_ff    <= sh_cnt_in;
         t1_cnt_ff    <= t1_cnt_in;
         t1_latch_ff  <= t1_latch_in;
         t1_run_ff    <= t1_run_in;
         t2_cnt_ff    <= t2_cnt_in;
         t2_latch_ff  <= t2_latch_in;
         t2_run_ff    <= t2_run_in;
         t2_exp_ff    <= t2_exp_in;
         ora_ff       <= ora_in;
         orb_ff       <= orb_in;
         ddra_ff      <= ddra_in;
         ddrb_ff      <= ddrb_in;
         pina_ff      <= pina_in;
         pinb_ff      <= pinb_in;
         ctrl_ff      <= ctrl_in;
      end
   end

   // Input register payload.
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_op_ff  <= req_tuser;
         s1_rs_ff  <= req_tdata[3:0];
         s1_wd_ff  <= req_tdata[11:4];
         s1_ps_ff  <= req_tdata[12];
         s1_pin_ff <= req_tdata[15:13];
         s1_ls_ff  <= req_tdata[16];
      end
   end

   // Result register payload, taken from the state after the request.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_rd_ff  <= rd_val;
         rsp_irq_ff <= |(ifr_in & ier_in);
         rsp_pa_ff  <= ora_in & ddra_in;
         rsp_pb_ff  <= orb_in & ddrb_in;
         rsp_shv_ff <= shv_val;
         rsp_shb_ff <= shb_val;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_shv_ff;
   assign rsp_tdata  = {7'd0, rsp_shb_ff, rsp_pb_ff, rsp_pa_ff, rsp_irq_ff, rsp_rd_ff};

   // A pending shift-out always has ticks left to count.
   a_shift_count: assert property (@(posedge clock) disable iff (reset)
      sh_pend_ff |-> (sh_cnt_ff != 4'd0))
      else $error("shift-out pending with an empty countdown");

   // Without a completed shift-out the byte field reads zero.
   a_shift_byte_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser) |-> (rsp_tdata[32:25] == 8'd0))
      else $error("shift-out byte nonzero without shift_out_valid");

   // While the result is stalled, the waiting request must not touch the flags.
   a_stall_holds_state: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && s1_valid_ff) |=> $stable(ifr_ff))
      else $error("interrupt flags changed while the result was stalled");

   // A freshly loaded result reports the interrupt level of the updated state.
   a_irq_matches: assert property (@(posedge clock) disable iff (reset)
      $past(fire) |-> (rsp_tdata[8] == (|(ifr_ff & ier_ff))))
      else $error("reported irq differs from flag and enable state");

endmodule : versatile_interface_adapter_unit

`default_nettype wire

### tb/versatile_interface_adapter_unit_tb.sv
// Self-checking testbench for versatile_interface_adapter_unit: queued requests drive the
// req_ stream, and a local behavioral predictor checks every result on the rsp_ stream.
// Depends on vau_pkg and the adapter RTL.
`timescale 1ns / 1ps

module versatile_interface_adapter_unit_tb;
   import vau_pkg::*;

   // Request kinds that the adapter has no meaning for.
   localparam logic [2:0] OP_SPARE_6 = 3'd6;
   localparam logic [2:0] OP_SPARE_7 = 3'd7;

   // ACR bit positions and modes used by the predictor.
   localparam int unsigned ACR_T2_PULSE = 5;
   localparam int unsigned ACR_SR_OUT   = 4;
   localparam logic [1:0]  T1_FREERUN_PB7 = 2'd3;

   // Interrupt flag masks.
   localparam logic [6:0] FL_CA2 = 7'b1 << FLAG_CA2;
   localparam logic [6:0] FL_CA1 = 7'b1 << FLAG_CA1;
   localparam logic [6:0] FL_SR  = 7'b1 << FLAG_SR;
   localparam logic [6:0] FL_CB2 = 7'b1 << FLAG_CB2;
   localparam logic [6:0] FL_CB1 = 7'b1 << FLAG_CB1;
   localparam logic [6:0] FL_T2  = 7'b1 << FLAG_T2;
   localparam logic [6:0] FL_T1  = 7'b1 << FLAG_T1;

   localparam int unsigned RANDOM_TARGET = 400;
   localparam int unsigned DRAIN_CYCLES  = 20;
   localparam int unsigned MAX_REPORTS   = 10;

   typedef struct {
      logic [2:0] op;
      logic [3:0] rs;
      logic [7:0] data;
      logic       port_sel;
      logic [2:0] pin;
      logic       line_sel;
   } adapter_req_t;

   typedef struct {
      logic [7:0] read_data;
      logic       irq;
      logic [7:0] pa_drive;
      logic [7:0] pb_drive;
      logic       so_valid;
      logic [7:0] so_byte;
   } adapter_rsp_t;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [REQ_DATA_W-1:0]   req_tdata = '0;
   logic [2:0]              req_tuser = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]   rsp_tdata;
   logic                    rsp_tuser;

   versatile_interface_adapter_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #5 clock = ~clock;

   // Requests waiting to be offered, and results predicted but not yet seen.
   adapter_req_t request_backlog[$];
   adapter_rsp_t predicted_rsps[$];
   adapter_req_t offered_req;
   int unsigned  total_requests;
   int unsigned  accepted_requests = 0;
   int unsigned  mismatch_count = 0;

   // Predictor copy of the adapter state.
   logic [7:0]  m_sr, m_acr, m_pcr, m_ifr;
   logic [6:0]  m_ier;
   logic        m_shift_busy;
   logic [7:0]  m_shift_byte;
   logic [3:0]  m_shift_left;
   logic [15:0] m_t1_cnt, m_t1_lat, m_t2_cnt, m_t2_lat;
   logic        m_t1_on, m_t2_on, m_t2_fired;
   logic [7:0]  m_or[2];
   logic [7:0]  m_ddr[2];
   logic [7:0]  m_pin[2];
   logic [3:0]  m_lines;

   // IFR bit 7 follows any enabled flag.
   function automatic void post_flags(input logic [6:0] f);
      m_ifr = {|(f & m_ier), f};
   endfunction

   // Level seen on a port: driven bits from the output register, the rest from the pins.
   function automatic logic [7:0] port_level(input int p);
      return (m_or[p] & m_ddr[p]) | (m_pin[p] & ~m_ddr[p]);
   endfunction

   // Apply one request to the predictor state and return the result it causes.
   function automatic adapter_rsp_t apply_request(input adapter_req_t r);
      adapter_rsp_t res;
      logic [1:0]   t1_mode;
      logic [2:0]   line_mode;
      logic         rising, old_lvl, no_flag;
      logic [6:0]   fl;
      int           lbit;
      res.read_data = '0;
      res.so_valid  = 1'b0;
      res.so_byte   = '0;
      case (r.op)
         OP_READ: begin
            case (r.rs)
               REG_ORB: begin
                  post_flags(m_ifr[6:0] & ~(FL_CB1 | FL_CB2));
                  res.read_data = port_level(1);
               end
               REG_ORA:   res.read_data = port_level(0);
               REG_DDRB:  res.read_data = m_ddr[1];
               REG_DDRA:  res.read_data = m_ddr[0];
               REG_T1C_L: begin
                  post_flags(m_ifr[6:0] & ~FL_T1);
                  res.read_data = m_t1_cnt[7:0];
               end
               REG_T1C_H: res.read_data = m_t1_cnt[15:8];
               REG_T1L_L: res.read_data = m_t1_lat[7:0];
               REG_T1L_H: res.read_data = m_t1_lat[15:8];
               REG_T2C_L: begin
                  post_flags(m_ifr[6:0] & ~FL_T2);
                  res.read_data = m_t2_cnt[7:0];
               end
               REG_T2C_H: res.read_data = m_t2_cnt[15:8];
               REG_SR: begin
                  post_flags(m_ifr[6:0] & ~FL_SR);
                  res.read_data = m_sr;
               end
               REG_ACR:   res.read_data = m_acr;
               REG_PCR:   res.read_data = m_pcr;
               REG_IFR:   res.read_data = m_ifr;
               REG_IER:   res.read_data = {1'b1, m_ier};
               default: begin
                  post_flags(m_ifr[6:0] & ~(FL_CA1 | FL_CA2));
                  res.read_data = port_level(0);
               end
            endcase
         end
         OP_WRITE: begin
            case (r.rs)
               REG_ORB: begin
                  m_or[1] = r.data;
                  post_flags(m_ifr[6:0] & ~(FL_CB1 | FL_CB2));
               end
               REG_DDRB: m_ddr[1] = r.data;
               REG_DDRA: m_ddr[0] = r.data;
               REG_T1C_L, REG_T1L_L: m_t1_lat[7:0] = r.data;
               REG_T1C_H: begin
                  post_flags(m_ifr[6:0] & ~FL_T1);
                  m_t1_lat[15:8] = r.data;
                  if (m_acr[7:6] == T1_ONESHOT_PB7 && m_ddr[1][7]) m_or[1][7] = 1'b0;
                  m_t1_cnt = m_t1_lat;
                  m_t1_on  = 1'b1;
               end
               REG_T1L_H: m_t1_lat[15:8] = r.data;
               REG_T2C_L: m_t2_lat[7:0] = r.data;
               REG_T2C_H: begin
                  m_t2_lat[15:8] = r.data;
                  post_flags(m_ifr[6:0] & ~FL_T2);
                  m_t2_cnt   = m_t2_lat;
                  m_t2_fired = 1'b0;
                  // In pulse-count mode the load does not start the timer.
                  m_t2_on    = !m_acr[ACR_T2_PULSE];
               end
               REG_SR: begin
                  m_sr = r.data;
                  post_flags(m_ifr[6:0] & ~FL_SR);
                  if (m_acr[ACR_SR_OUT]) begin
                     m_shift_byte = r.data;
                     m_shift_busy = 1'b1;
                     m_shift_left = SHIFT_TICKS;
                  end
               end
               REG_ACR: begin
                  // Any change of the shift mode drops a shift-out in progress.
                  if (m_acr[4:2] != r.data[4:2] && m_shift_busy) begin
                     m_shift_busy = 1'b0;
                     m_shift_left = '0;
                  end
                  m_acr = r.data;
               end
               REG_PCR: m_pcr = r.data;
               REG_IFR: post_flags(m_ifr[6:0] & ~r.data[6:0]);
               REG_IER: begin
                  if (r.data[7]) m_ier = m_ier | r.data[6:0];
                  else m_ier = m_ier & ~r.data[6:0];
                  post_flags(m_ifr[6:0]);
               end
               default: begin
                  m_or[0] = r.data;
                  post_flags(m_ifr[6:0] & ~(FL_CA1 | FL_CA2));
               end
            endcase
         end
         OP_TICK: begin
            // Timer 1, then timer 2, then the shift-out countdown.
            if (m_t1_on) begin
               if (m_t1_cnt == 16'd0) begin
                  t1_mode = m_acr[7:6];
                  if (t1_mode[0]) begin
                     m_t1_cnt = m_t1_lat;
                     if (t1_mode == T1_FREERUN_PB7 && m_ddr[1][7]) m_or[1][7] = ~m_or[1][7];
                  end else begin
                     m_t1_on  = 1'b0;
                     m_t1_cnt = TIMER_ALL_ONES;
                     if (t1_mode == T1_ONESHOT_PB7 && m_ddr[1][7]) m_or[1][7] = 1'b1;
                  end
                  post_flags(m_ifr[6:0] | FL_T1);
               end else begin
                  m_t1_cnt = m_t1_cnt - 16'd1;
               end
            end
            if (m_t2_on) begin
               if (m_t2_cnt == 16'd0) begin
                  m_t2_cnt = TIMER_ALL_ONES;
                  if (!m_t2_fired) begin
                     m_t2_fired = 1'b1;
                     post_flags(m_ifr[6:0] | FL_T2);
                  end
               end else begin
                  m_t2_cnt = m_t2_cnt - 16'd1;
               end
            end
            if (m_shift_busy) begin
               if (m_shift_left <= 4'd1) begin
                  m_shift_left = '0;
                  m_shift_busy = 1'b0;
                  res.so_valid = 1'b1;
                  res.so_byte  = m_shift_byte;
                  post_flags(m_ifr[6:0] | FL_SR);
               end else begin
                  m_shift_left = m_shift_left - 4'd1;
               end
            end
         end
         OP_SET_PIN: m_pin[r.port_sel][r.pin] = r.data[0];
         OP_SET_LINE: begin
            lbit = r.port_sel * 2 + r.line_sel;
            old_lvl = m_lines[lbit];
            m_lines[lbit] = r.data[0];
            if (!r.line_sel) begin
               rising  = r.port_sel ? m_pcr[4] : m_pcr[0];
               fl      = r.port_sel ? FL_CB1 : FL_CA1;
               no_flag = 1'b0;
            end else begin
               // CA2/CB2 output modes store the level and raise no flag.
               line_mode = r.port_sel ? m_pcr[7:5] : m_pcr[3:1];
               no_flag   = line_mode[2];
               rising    = line_mode[1];
               fl        = r.port_sel ? FL_CB2 : FL_CA2;
            end
            if (!no_flag && (rising ? (!old_lvl && r.data[0]) : (old_lvl && !r.data[0])))
               post_flags(m_ifr[6:0] | fl);
         end
         OP_SHIFT_IN: begin
            if (!m_acr[ACR_SR_OUT] && m_acr[3:2] == SR_MODE_EXT_IN) begin
               m_sr = r.data;
               post_flags(m_ifr[6:0] | FL_SR);
            end
         end
         default: ;
      endcase
      res.irq      = m_ifr[7];
      res.pa_drive = m_or[0] & m_ddr[0];
      res.pb_drive = m_or[1] & m_ddr[1];
      return res;
   endfunction

   // Stimulus helpers; fields a request kind does not use are randomized.
   task automatic queue_req(input logic [2:0] op, input logic [3:0] rs, input logic [7:0] d,
                            input logic ps, input logic [2:0] pi, input logic ls);
      adapter_req_t r;
      r.op = op;
      r.rs = rs;
      r.data = d;
      r.port_sel = ps;
      r.pin = pi;
      r.line_sel = ls;
      request_backlog.push_back(r);
   endtask

   task automatic queue_write(input logic [3:0] rs, input logic [7:0] d);
      queue_req(OP_WRITE, rs, d, $urandom, $urandom, $urandom);
   endtask

   task automatic queue_read(input logic [3:0] rs);
      queue_req(OP_READ, rs, $urandom, $urandom, $urandom, $urandom);
   endtask

   task automatic queue_ticks(input int n);
      for (int i = 0; i < n; i++)
         queue_req(OP_TICK, $urandom, $urandom, $urandom, $urandom, $urandom);
   endtask

   // Mostly tiny timer values so timeouts happen often; now and then a full one.
   function automatic logic [7:0] timer_byte(input int unsigned small_max);
      if ($urandom_range(0, 9) == 0) return $urandom;
      return $urandom_range(0, small_max);
   endfunction

   // Build the whole request list, then wait for the run to drain and judge it.
   initial begin : stimulus
      int unsigned n;
      int unsigned k;
      logic [7:0]  v;

      // Directed requests: extremes, every kind and the corner behaviors.
      queue_read(REG_ORA);
      queue_read(REG_IER);
      queue_write(REG_DDRA, 8'hFF);
      queue_write(REG_ORA_HS, 8'hFF);
      queue_write(REG_DDRB, 8'h80);
      queue_write(REG_ACR, 8'hC0);
      queue_write(REG_T1L_L, 8'h00);
      queue_write(REG_T1C_H, 8'h00);
      queue_ticks(2);
      queue_write(REG_IER, 8'hFF);
      queue_read(REG_T1C_L);
      queue_write(REG_ACR, 8'h20);
      queue_write(REG_T2C_L, 8'hFF);
      queue_write(REG_T2C_H, 8'hFF);
      queue_read(REG_T2C_H);
      queue_write(REG_ACR, 8'h1C);
      queue_write(REG_SR, 8'h5A);
      queue_write(REG_ACR, 8'h0C);
      queue_req(OP_SHIFT_IN, 4'h0, 8'hA5, 1'b0, 3'd0, 1'b0);
      queue_read(REG_SR);
      queue_write(REG_PCR, 8'h0E);
      queue_req(OP_SET_LINE, 4'h0, 8'h01, 1'b0, 3'd0, 1'b1);
      queue_req(OP_SET_PIN, 4'h0, 8'h00, 1'b1, 3'd7, 1'b0);
      queue_req(OP_SPARE_7, 4'hF, 8'hFF, 1'b1, 3'd7, 1'b1);
      queue_req(OP_SPARE_6, 4'h0, 8'h00, 1'b0, 3'd0, 1'b0);
      queue_write(REG_IER, 8'h7F);
      queue_write(REG_ORA, 8'h00);

      // Random part: short well-formed sequences with random content, plus noise.
      n = request_backlog.size() + RANDOM_TARGET;
      while (request_backlog.size() < n) begin
         case ($urandom_range(0, 8))
            0: begin
               // Timer 1 in a random mode, sometimes with PB7 driven.
               if ($urandom_range(0, 2) == 0) queue_write(REG_DDRB, $urandom);
               queue_write(REG_ACR, $urandom);
               queue_write($urandom_range(0, 1) ? REG_T1L_L : REG_T1C_L, timer_byte(6));
               if ($urandom_range(0, 4) == 0) queue_write(REG_T1L_H, timer_byte(0));
               queue_write(REG_T1C_H, timer_byte(0));
               queue_ticks($urandom_range(1, 14));
               if ($urandom_range(0, 2) == 0) queue_read(REG_T1L_L + $urandom_range(0, 1));
               queue_read(REG_T1C_L + $urandom_range(0, 1));
            end
            1: begin
               // Timer 2, occasionally in pulse-count mode.
               if ($urandom_range(0, 3) == 0) queue_write(REG_ACR, $urandom);
               queue_write(REG_T2C_L, timer_byte(6));
               queue_write(REG_T2C_H, timer_byte(0));
               queue_ticks($urandom_range(1, 12));
               queue_read(REG_T2C_L + $urandom_range(0, 1));
               queue_read(REG_IFR);
            end
            2: begin
               // Shift-out, sometimes cut short by a shift mode change.
               v = $urandom;
               v[ACR_SR_OUT] = 1'b1;
               queue_write(REG_ACR, v);
               queue_write(REG_SR, $urandom);
               k = $urandom_range(0, 10);
               if ($urandom_range(0, 4) == 0) begin
                  queue_ticks(k / 2);
                  queue_write(REG_ACR, $urandom);
                  queue_ticks(k - k / 2);
               end else begin
                  queue_ticks(k);
               end
               queue_read($urandom_range(0, 1) ? REG_SR : REG_IFR);
            end
            3: begin
               // Shift-in in external input mode, now and then in another mode.
               v = $urandom;
               if ($urandom_range(0, 4) != 0) begin
                  v[ACR_SR_OUT] = 1'b0;
                  v[3:2] = SR_MODE_EXT_IN;
               end
               queue_write(REG_ACR, v);
               k = $urandom_range(1, 3);
               for (int i = 0; i < k; i++)
                  queue_req(OP_SHIFT_IN, $urandom, $urandom, $urandom, $urandom, $urandom);
               if ($urandom_range(0, 3) == 0) queue_write(REG_SR, $urandom);
               queue_read(REG_SR);
               queue_read(REG_IFR);
            end
            4: begin
               // Control lines against a random PCR.
               queue_write(REG_PCR, $urandom);
               if ($urandom_range(0, 2) == 0) queue_write(REG_IER, $urandom);
               k = $urandom_range(2, 6);
               for (int i = 0; i < k; i++)
                  queue_req(OP_SET_LINE, $urandom, $urandom, $urandom, $urandom, $urandom);
               queue_read(REG_IFR);
               case ($urandom_range(0, 3))
                  0: queue_read(REG_ORA_HS);
                  1: queue_read(REG_ORB);
                  2: queue_write(REG_ORA_HS, $urandom);
                  default: queue_write(REG_ORB, $urandom);
               endcase
            end
            5: begin
               // Port registers and pins.
               queue_write($urandom_range(0, 1) ? REG_DDRA : REG_DDRB, $urandom);
               case ($urandom_range(0, 2))
                  0: queue_write(REG_ORA, $urandom);
                  1: queue_write(REG_ORA_HS, $urandom);
                  default: queue_write(REG_ORB, $urandom);
               endcase
               k = $urandom_range(1, 4);
               for (int i = 0; i < k; i++)
                  queue_req(OP_SET_PIN, $urandom, $urandom, $urandom, $urandom, $urandom);
               queue_read(REG_ORB);
               queue_read(REG_ORA);
               queue_read($urandom_range(0, 1) ? REG_DDRA : REG_DDRB);
            end
            6: begin
               // Interrupt enable and flag registers.
               queue_write(REG_IER, $urandom);
               queue_read(REG_IER);
               queue_read(REG_IFR);
               queue_write(REG_IFR, $urandom);
               queue_read($urandom_range(REG_ACR, REG_PCR));
            end
            default: begin
               // Noise: any kind, any field value.
               k = $urandom_range(1, 4);
               for (int i = 0; i < k; i++)
                  queue_req($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
            end
         endcase
      end
      total_requests = request_backlog.size();

      while (accepted_requests < total_requests) @(posedge clock);
      while (predicted_rsps.size() != 0) @(posedge clock);
      // Leave room for stray results before judging the run.
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && predicted_rsps.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

   // Hold reset at the start, then release it.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
   end

   // Generous upper bound on the run.
   initial begin
      #2_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   // Request driver: bursts of random length separated by random gaps.
   int unsigned burst_left;
   int unsigned gap_left;
   logic [REQ_DATA_W-1:0] packed_req;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = $urandom_range(1, 24);
         gap_left = 0;
         m_sr = '0;
         m_acr = '0;
         m_pcr = '0;
         m_ifr = '0;
         m_ier = '0;
         m_shift_busy = 1'b0;
         m_shift_byte = '0;
         m_shift_left = '0;
         m_t1_cnt = '0;
         m_t1_lat = '0;
         m_t2_cnt = '0;
         m_t2_lat = '0;
         m_t1_on = 1'b0;
         m_t2_on = 1'b0;
         m_t2_fired = 1'b0;
         m_or[0] = '0;
         m_or[1] = '0;
         m_ddr[0] = '0;
         m_ddr[1] = '0;
         m_pin[0] = PIN_A_RESET;
         m_pin[1] = PIN_B_RESET;
         m_lines = '0;
      end else begin
         if (req_tvalid && req_tready) begin
            predicted_rsps.push_back(apply_request(offered_req));
            accepted_requests++;
         end
         // The slot is free when nothing is offered or the offer was just taken.
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (request_backlog.size() > 0) begin
               offered_req = request_backlog.pop_front();
               packed_req = '0;
               packed_req[16:0] = {offered_req.line_sel, offered_req.pin, offered_req.port_sel,
                                   offered_req.data, offered_req.rs};
               req_tdata <= packed_req;
               req_tuser <= offered_req.op;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result receiver: phases of full rate, light and heavy stalling, and two long
   // hold-offs during which the adapter fills up and drops req_tready.
   int unsigned rx_cycle = 0;
   int unsigned hold_left = 0;
   int unsigned phase_left = 0;
   int unsigned phase_style = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycle++;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (rx_cycle == 150 || rx_cycle == 1500) begin
            hold_left = 80;
            rsp_tready <= 1'b0;
         end else begin
            if (phase_left == 0) begin
               phase_style = $urandom_range(0, 2);
               phase_left = $urandom_range(10, 60);
            end
            phase_left--;
            case (phase_style)
               0: rsp_tready <= 1'b1;
               1: rsp_tready <= ($urandom_range(0, 99) < 70);
               default: rsp_tready <= ($urandom_range(0, 99) < 30);
            endcase
         end
      end
   end

   // Result monitor: compare each accepted result with the oldest prediction.
   adapter_rsp_t want;
   adapter_rsp_t got;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_data = rsp_tdata[7:0];
         got.irq       = rsp_tdata[8];
         got.pa_drive  = rsp_tdata[16:9];
         got.pb_drive  = rsp_tdata[24:17];
         got.so_byte   = rsp_tdata[32:25];
         got.so_valid  = rsp_tuser;
         if (predicted_rsps.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
               $display("%0t: result with no request outstanding: rd=%h irq=%b", $realtime,
                        got.read_data, got.irq);
         end else begin
            want = predicted_rsps.pop_front();
            if (got.read_data !== want.read_data || got.irq !== want.irq ||
                got.pa_drive !== want.pa_drive || got.pb_drive !== want.pb_drive ||
                got.so_valid !== want.so_valid || got.so_byte !== want.so_byte) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $display({"%0t: mismatch: expected rd=%h irq=%b pa=%h pb=%h sov=%b sob=%h",
                            " / actual rd=%h irq=%b pa=%h pb=%h sov=%b sob=%h"}, $realtime,
                           want.read_data, want.irq, want.pa_drive, want.pb_drive,
                           want.so_valid, want.so_byte, got.read_data, got.irq,
                           got.pa_drive, got.pb_drive, got.so_valid, got.so_byte);
            end
         end
      end
   end

endmodule
